[sv/mdpc_pkg.sv]
package mdpc_pkg;

  // Default build-time sizes
  localparam int HALF_WINDOW_DEF = 10;
  localparam int MAX_COLS_DEF    = 1024;
  localparam int MAX_ROWS_DEF    = 1024;

  // Fixed field widths
  localparam int DEPTH_BITS  = 16;
  localparam int COLOUR_BITS = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int INV_FRAC    = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FY    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H   = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_MIN_DEPTH = 16'd10;
  localparam logic [15:0] RST_MAX_DEPTH = 16'd2000;
  localparam logic [13:0] RST_CENTER_X  = 14'd5112;
  localparam logic [13:0] RST_CENTER_Y  = 14'd3832;
  localparam logic [23:0] RST_INV_FX    = 24'd31957;
  localparam logic [23:0] RST_INV_FY    = 24'd31957;
  localparam logic [10:0] RST_FRAME_W   = 11'd640;
  localparam logic [10:0] RST_FRAME_H   = 11'd480;

  // Item kinds
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] depth_mm;
    logic        mask_bit;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
  } pix_item_t;

  typedef struct packed {
    logic               keep;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic [15:0]        z_mm;
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
    logic [7:0]         out_alpha;
    logic               frame_last;
  } point_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic new_frame;
    logic calc_size;
    logic write_pix;
    logic h_update;
    logic v_addr;
    logic v_calc;
    logic mul1;
    logic mul2;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_flush;
    logic start_frame;
    logic emit_due;
    logic h_pending;
    logic out_free;
  } dp_status_t;

endpackage

[sv/mdpc_pix_if.sv]
interface mdpc_pix_if;
  import mdpc_pkg::*;

  logic      valid;
  logic      ready;
  pix_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/mdpc_pt_if.sv]
interface mdpc_pt_if;
  import mdpc_pkg::*;

  logic        valid;
  logic        ready;
  point_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/mdpc_ram.sv]
module mdpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/mdpc_ctrl.sv]
module mdpc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mdpc_pkg::dp_status_t status,
  output mdpc_pkg::dp_cmd_t    cmd
);
  import mdpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SIZE, S_WRITE, S_HCHK, S_HUPD,
    S_VADDR, S_VWAIT, S_VCALC, S_MUL1, S_MUL2, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Sequencing of one item
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        if (status.is_flush) begin
          state_nxt = status.emit_due ? S_HCHK : S_IDLE;
        end else if (status.start_frame) begin
          cmd.new_frame = 1'b1;
          state_nxt     = S_SIZE;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_SIZE: begin
        cmd.calc_size = 1'b1;
        state_nxt     = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_pix = 1'b1;
        state_nxt     = S_HCHK;
      end
      S_HCHK: begin
        if (status.h_pending) begin
          state_nxt = S_HUPD;
        end else if (status.emit_due) begin
          state_nxt = S_VADDR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_HUPD: begin
        cmd.h_update = 1'b1;
        state_nxt    = S_HCHK;
      end
      S_VADDR: begin
        cmd.v_addr = 1'b1;
        state_nxt  = S_VWAIT;
      end
      S_VWAIT: begin
        state_nxt = S_VCALC;
      end
      S_VCALC: begin
        cmd.v_calc = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[sv/mdpc_dp.sv]
module mdpc_dp #(
  parameter int HALF_WINDOW = mdpc_pkg::HALF_WINDOW_DEF,
  parameter int MAX_COLS    = mdpc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = mdpc_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mdpc_pkg::pix_item_t             in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mdpc_pkg::point_item_t           out_item,
  input  mdpc_pkg::dp_cmd_t               cmd,
  output mdpc_pkg::dp_status_t            status
);
  import mdpc_pkg::*;

  localparam int CW         = $clog2(MAX_COLS);
  localparam int RWD        = $clog2(MAX_ROWS);
  localparam int FWW        = $clog2(MAX_COLS + 1);
  localparam int FHW        = $clog2(MAX_ROWS + 1);
  localparam int FPW        = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam int RING_DEPTH = (HALF_WINDOW + 1) * MAX_COLS;
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int RUN_MAX    = 2 * HALF_WINDOW + 1;
  localparam int RUN_W      = $clog2(2 * HALF_WINDOW + 2);
  localparam int HWW        = $clog2(HALF_WINDOW + 1);
  localparam int CRW        = (CW > RWD) ? CW : RWD;
  localparam int MAGW       = (CRW + 4 > 14) ? CRW + 4 : 14;
  localparam int PIX_W      = DEPTH_BITS + COLOUR_BITS;
  localparam int TW         = MAGW + DEPTH_BITS;
  localparam int PW         = TW + INV_FRAC;

  // Round at the fraction point, apply sign, saturate to 32 bits
  function automatic logic [31:0] sat_coord(input logic neg, input logic [63:0] prod);
    logic [63:0] mag;
    mag = (prod + (64'(1) << (INV_FRAC - 1))) >> INV_FRAC;
    if (!neg) begin
      return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    if (mag > 64'h8000_0000) begin
      mag = 64'h8000_0000;
    end
    return 32'(64'h1_0000_0000 - mag);
  endfunction

  // Configuration registers
  logic [15:0] min_r, max_r;
  logic [13:0] cx_r, cy_r;
  logic [23:0] ifx_r, ify_r;
  logic [10:0] cfw_r, cfh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= RST_MIN_DEPTH;
      max_r <= RST_MAX_DEPTH;
      cx_r  <= RST_CENTER_X;
      cy_r  <= RST_CENTER_Y;
      ifx_r <= RST_INV_FX;
      ify_r <= RST_INV_FY;
      cfw_r <= RST_FRAME_W;
      cfh_r <= RST_FRAME_H;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_DEPTH: min_r <= cfg_data[15:0];
        CFG_MAX_DEPTH: max_r <= cfg_data[15:0];
        CFG_CENTER_X:  cx_r  <= cfg_data[13:0];
        CFG_CENTER_Y:  cy_r  <= cfg_data[13:0];
        CFG_INV_FX:    ifx_r <= cfg_data[23:0];
        CFG_INV_FY:    ify_r <= cfg_data[23:0];
        CFG_FRAME_W:   cfw_r <= cfg_data[10:0];
        CFG_FRAME_H:   cfh_r <= cfg_data[10:0];
        default:       min_r <= min_r;
      endcase
    end
  end

  // Captured item
  logic                   flush_r;
  logic [DEPTH_BITS-1:0]  dep_r;
  logic                   msk_r;
  logic [COLOUR_BITS-1:0] colour_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dep_r    <= in_item.depth_mm;
      msk_r    <= in_item.mask_bit;
      colour_r <= {in_item.alpha, in_item.red, in_item.green, in_item.blue};
    end
  end

  // Frame geometry and cursors
  logic [FWW-1:0]   fw_r;
  logic [FHW-1:0]   fh_r;
  logic [FPW-1:0]   fp_r, lat_r;
  logic [FPW-1:0]   in_count_r, hc_r, out_count_r;
  logic [AW-1:0]    in_addr_r, h_addr_r, o_addr_r;
  logic [CW-1:0]    in_col_r, h_col_r, o_col_r;
  logic [RWD-1:0]   o_row_r;
  logic             h_first_row_r;
  logic [RUN_W-1:0] row_run_r;
  logic [AW-1:0]    vaddr_r;
  logic [RUN_W-1:0] v_need_r;
  logic             out_valid_r;

  // Memory read data
  logic [PIX_W-1:0] pix_rdata;
  logic [RUN_W-1:0] rrun_rdata, crun_rdata, colrun_rdata;

  // Frame size clamp
  logic [FWW-1:0] fw_new;
  logic [FHW-1:0] fh_new;

  always_comb begin
    if (cfw_r == '0) begin
      fw_new = FWW'(1);
    end else if (32'(cfw_r) > 32'(MAX_COLS)) begin
      fw_new = FWW'(MAX_COLS);
    end else begin
      fw_new = FWW'(cfw_r);
    end
    if (cfh_r == '0) begin
      fh_new = FHW'(1);
    end else if (32'(cfh_r) > 32'(MAX_ROWS)) begin
      fh_new = FHW'(MAX_ROWS);
    end else begin
      fh_new = FHW'(cfh_r);
    end
  end

  logic [FWW+FHW-1:0] area;
  assign area = fw_r * fh_r;

  // Row run of mask ones ending at the new pixel
  logic [RUN_W-1:0] r_new;
  always_comb begin
    if (!msk_r) begin
      r_new = '0;
    end else if (in_col_r == '0) begin
      r_new = RUN_W'(1);
    end else if (row_run_r == RUN_W'(RUN_MAX)) begin
      r_new = row_run_r;
    end else begin
      r_new = row_run_r + RUN_W'(1);
    end
  end

  // Horizontal check: look-ahead column and needed run length
  logic [FWW-1:0]   h_rem;
  logic [HWW-1:0]   h_off;
  logic [AW:0]      h_sum;
  logic [AW-1:0]    rrun_raddr;
  logic [RUN_W-1:0] h_back, h_need, c_new;
  logic             h_ok;

  always_comb begin
    h_rem = fw_r - FWW'(1) - FWW'(h_col_r);
    h_off = (h_rem > FWW'(HALF_WINDOW)) ? HWW'(HALF_WINDOW) : h_rem[HWW-1:0];
    h_sum = {1'b0, h_addr_r} + (AW+1)'(h_off);
    if (h_sum >= (AW+1)'(RING_DEPTH)) begin
      rrun_raddr = AW'(h_sum - (AW+1)'(RING_DEPTH));
    end else begin
      rrun_raddr = h_sum[AW-1:0];
    end
    h_back = (h_col_r > CW'(HALF_WINDOW)) ? RUN_W'(HALF_WINDOW) : RUN_W'(h_col_r);
    h_need = RUN_W'(h_off) + h_back + RUN_W'(1);
    h_ok   = (rrun_rdata >= h_need);
    // column run of horizontal passes
    if (!h_ok) begin
      c_new = '0;
    end else if (h_first_row_r) begin
      c_new = RUN_W'(1);
    end else if (colrun_rdata == RUN_W'(RUN_MAX)) begin
      c_new = colrun_rdata;
    end else begin
      c_new = colrun_rdata + RUN_W'(1);
    end
  end

  // Vertical check: look-ahead row and needed run length
  logic [FHW-1:0]     v_rem;
  logic [HWW-1:0]     v_k;
  logic [HWW+FWW-1:0] v_kw;
  logic [AW:0]        v_sum;
  logic [AW-1:0]      v_addr_new;
  logic [RUN_W-1:0]   v_back;

  always_comb begin
    v_rem = fh_r - FHW'(1) - FHW'(o_row_r);
    v_k   = (v_rem > FHW'(HALF_WINDOW)) ? HWW'(HALF_WINDOW) : v_rem[HWW-1:0];
    v_kw  = v_k * fw_r;
    v_sum = {1'b0, o_addr_r} + (AW+1)'(v_kw);
    if (v_sum >= (AW+1)'(RING_DEPTH)) begin
      v_addr_new = AW'(v_sum - (AW+1)'(RING_DEPTH));
    end else begin
      v_addr_new = v_sum[AW-1:0];
    end
    v_back = (o_row_r > RWD'(HALF_WINDOW)) ? RUN_W'(HALF_WINDOW) : RUN_W'(o_row_r);
  end

  // Horizontal cursor limit: HALF_WINDOW behind input, all of it once complete
  logic [FPW-1:0] h_limit;
  always_comb begin
    if (in_count_r == fp_r) begin
      h_limit = fp_r;
    end else if (in_count_r > FPW'(HALF_WINDOW)) begin
      h_limit = in_count_r - FPW'(HALF_WINDOW);
    end else begin
      h_limit = '0;
    end
  end

  logic [FPW-1:0] out_next;
  assign out_next = out_count_r + FPW'(1);

  // Cursor and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r       <= 1'b0;
      fw_r          <= FWW'(1);
      fh_r          <= FHW'(1);
      fp_r          <= '0;
      lat_r         <= '0;
      in_count_r    <= '0;
      hc_r          <= '0;
      out_count_r   <= '0;
      in_addr_r     <= '0;
      h_addr_r      <= '0;
      o_addr_r      <= '0;
      in_col_r      <= '0;
      h_col_r       <= '0;
      o_col_r       <= '0;
      o_row_r       <= '0;
      h_first_row_r <= 1'b1;
      row_run_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.capture) begin
        flush_r <= (in_item.mode == MODE_FLUSH);
      end
      if (cmd.new_frame) begin
        fw_r          <= fw_new;
        fh_r          <= fh_new;
        in_count_r    <= '0;
        hc_r          <= '0;
        out_count_r   <= '0;
        in_addr_r     <= '0;
        h_addr_r      <= '0;
        o_addr_r      <= '0;
        in_col_r      <= '0;
        h_col_r       <= '0;
        o_col_r       <= '0;
        o_row_r       <= '0;
        h_first_row_r <= 1'b1;
      end
      if (cmd.calc_size) begin
        fp_r  <= FPW'(area);
        lat_r <= FPW'(fw_r) * FPW'(HALF_WINDOW) + FPW'(HALF_WINDOW);
      end
      // store pixel
      if (cmd.write_pix) begin
        row_run_r  <= r_new;
        in_count_r <= in_count_r + FPW'(1);
        in_addr_r  <= (in_addr_r == AW'(RING_DEPTH - 1)) ? '0 : in_addr_r + AW'(1);
        in_col_r   <= (FWW'(in_col_r) + FWW'(1) == fw_r) ? '0 : in_col_r + CW'(1);
      end
      // horizontal step
      if (cmd.h_update) begin
        hc_r     <= hc_r + FPW'(1);
        h_addr_r <= (h_addr_r == AW'(RING_DEPTH - 1)) ? '0 : h_addr_r + AW'(1);
        if (FWW'(h_col_r) + FWW'(1) == fw_r) begin
          h_col_r       <= '0;
          h_first_row_r <= 1'b0;
        end else begin
          h_col_r <= h_col_r + CW'(1);
        end
      end
      if (cmd.v_addr) begin
        vaddr_r  <= v_addr_new;
        v_need_r <= RUN_W'(v_k) + v_back + RUN_W'(1);
      end
      // output slot and output cursor
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        if (out_next >= fp_r) begin
          in_count_r    <= '0;
          hc_r          <= '0;
          out_count_r   <= '0;
          in_addr_r     <= '0;
          h_addr_r      <= '0;
          o_addr_r      <= '0;
          in_col_r      <= '0;
          h_col_r       <= '0;
          o_col_r       <= '0;
          o_row_r       <= '0;
          h_first_row_r <= 1'b1;
        end else begin
          out_count_r <= out_next;
          o_addr_r    <= (o_addr_r == AW'(RING_DEPTH - 1)) ? '0 : o_addr_r + AW'(1);
          if (FWW'(o_col_r) + FWW'(1) == fw_r) begin
            o_col_r <= '0;
            o_row_r <= o_row_r + RWD'(1);
          end else begin
            o_col_r <= o_col_r + CW'(1);
          end
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Line stores
  mdpc_ram #(.WIDTH(PIX_W), .DEPTH(RING_DEPTH)) u_pix (
    .clk   (clk),
    .we    (cmd.write_pix),
    .waddr (in_addr_r),
    .wdata ({colour_r, dep_r}),
    .raddr (o_addr_r),
    .rdata (pix_rdata)
  );

  mdpc_ram #(.WIDTH(RUN_W), .DEPTH(RING_DEPTH)) u_rrun (
    .clk   (clk),
    .we    (cmd.write_pix),
    .waddr (in_addr_r),
    .wdata (r_new),
    .raddr (rrun_raddr),
    .rdata (rrun_rdata)
  );

  mdpc_ram #(.WIDTH(RUN_W), .DEPTH(RING_DEPTH)) u_crun (
    .clk   (clk),
    .we    (cmd.h_update),
    .waddr (h_addr_r),
    .wdata (c_new),
    .raddr (vaddr_r),
    .rdata (crun_rdata)
  );

  mdpc_ram #(.WIDTH(RUN_W), .DEPTH(MAX_COLS)) u_colrun (
    .clk   (clk),
    .we    (cmd.h_update),
    .waddr (h_col_r),
    .wdata (c_new),
    .raddr (h_col_r),
    .rdata (colrun_rdata)
  );

  // Depth test, window test and offsets
  logic                   keep_r, negx_r, negy_r;
  logic [DEPTH_BITS-1:0]  z_r;
  logic [COLOUR_BITS-1:0] pcol_r;
  logic [MAGW-1:0]        magx_r, magy_r;
  logic [TW-1:0]          tx_r, ty_r;
  logic [PW-1:0]          px_r, py_r;

  logic [DEPTH_BITS-1:0] d_rd;
  logic [MAGW-1:0]       ax, ay, cxe, cye;

  always_comb begin
    d_rd = pix_rdata[DEPTH_BITS-1:0];
    ax   = MAGW'({o_col_r, 4'b0000});
    ay   = MAGW'({o_row_r, 4'b0000});
    cxe  = MAGW'(cx_r);
    cye  = MAGW'(cy_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.v_calc) begin
      keep_r <= (d_rd >= min_r) && (d_rd <= max_r) && (crun_rdata >= v_need_r);
      z_r    <= d_rd;
      pcol_r <= pix_rdata[PIX_W-1:DEPTH_BITS];
      negx_r <= (ax < cxe);
      negy_r <= (ay < cye);
      magx_r <= (ax < cxe) ? cxe - ax : ax - cxe;
      magy_r <= (ay < cye) ? cye - ay : ay - cye;
    end
    if (cmd.mul1) begin
      tx_r <= magx_r * z_r;
      ty_r <= magy_r * z_r;
    end
    if (cmd.mul2) begin
      px_r <= tx_r * ifx_r;
      py_r <= ty_r * ify_r;
    end
  end

  // Output register
  point_item_t out_r;
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.keep       <= keep_r;
      out_r.x_pos      <= keep_r ? sat_coord(negx_r, 64'(px_r)) : '0;
      out_r.y_pos      <= keep_r ? sat_coord(negy_r, 64'(py_r)) : '0;
      out_r.z_mm       <= keep_r ? z_r : '0;
      out_r.out_blue   <= keep_r ? pcol_r[7:0] : '0;
      out_r.out_green  <= keep_r ? pcol_r[15:8] : '0;
      out_r.out_red    <= keep_r ? pcol_r[23:16] : '0;
      out_r.out_alpha  <= keep_r ? pcol_r[31:24] : '0;
      out_r.frame_last <= (out_next == fp_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Status to controller
  always_comb begin
    status.is_flush    = flush_r;
    status.start_frame = (in_count_r == '0) || (in_count_r == fp_r);
    status.emit_due    = flush_r ? ((in_count_r != '0) && (in_count_r == fp_r)
                                    && (out_count_r < fp_r))
                                 : (in_count_r > lat_r);
    status.h_pending   = (hc_r < h_limit);
    status.out_free    = !out_valid_r || out_ready;
  end

endmodule

[sv/masked_depth_to_point_cloud.sv]
// A pixel that yields a point goes through capture, start, write, horizontal check,
// vertical address and read, depth and window test, the multiplies and the load of the
// output register; a flush tick that yields one skips the write. A frame's first pixel
// adds a size step, each pending horizontal step an update and a recheck (one per pixel
// mid-frame, up to HALF_WINDOW+1 after the frame's last pixel); the load waits while the
// output register is full. A new item is taken the cycle after the previous one finishes.
// Synchronous active-low reset clears all cursors and loads the register defaults.
module masked_depth_to_point_cloud #(
  parameter int HALF_WINDOW = mdpc_pkg::HALF_WINDOW_DEF,
  parameter int MAX_COLS    = mdpc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = mdpc_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mdpc_pix_if.sink                        in_ch,
  mdpc_pt_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [mdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mdpc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller
  mdpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath with line stores
  mdpc_dp #(
    .HALF_WINDOW (HALF_WINDOW),
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_ch.payload),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[tb/tb_masked_depth_to_point_cloud.sv]
`timescale 1ns / 1ps

module tb_masked_depth_to_point_cloud;
  import mdpc_pkg::*;

  localparam int HW         = HALF_WINDOW_DEF;
  localparam int STORE_SZ   = 2048;
  localparam int CYCLE_CAP  = 1500000;
  localparam int TAIL_WAIT  = 80;
  localparam int RAND_ITEMS = 350;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mdpc_pix_if pix_ch ();
  mdpc_pt_if  pt_ch ();

  masked_depth_to_point_cloud i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_ch),
    .out_ch    (pt_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock, 10 ns period
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Predictor state: registers, frame cursors and the stored frame
  logic [23:0] reg_val [0:7];
  int unsigned fr_w, fr_h, fr_pix, in_cnt, out_cnt, out_col, out_row;
  logic [15:0] depth_mem  [0:STORE_SZ-1];
  logic [31:0] colour_mem [0:STORE_SZ-1];
  bit          mask_mem   [0:STORE_SZ-1];

  point_item_t point_q[$];
  int          err_cnt;
  int          cyc_cnt;
  int          burst_left;
  int          rand_sent;
  bit          hold_req;
  bit          offering;

  function automatic int unsigned reg_width(int idx);
    case (idx)
      CFG_MIN_DEPTH, CFG_MAX_DEPTH: reg_width = 16;
      CFG_CENTER_X, CFG_CENTER_Y:   reg_width = 14;
      CFG_INV_FX, CFG_INV_FY:       reg_width = 24;
      default:                      reg_width = 11;
    endcase
  endfunction

  function automatic void frame_idle();
    in_cnt = 0; out_cnt = 0; out_col = 0; out_row = 0;
  endfunction

  function automatic int unsigned clamp_size(logic [23:0] v);
    if (v[10:0] < 1) return 1;
    if (v[10:0] > MAX_COLS_DEF) return MAX_COLS_DEF;
    return v[10:0];
  endfunction

  // Back-projection of one axis, rounded half away from zero, saturated
  function automatic logic [31:0] back_project(int unsigned pos, logic [13:0] ctr,
                                               logic [15:0] d, logic [23:0] inv);
    logic [63:0]  a, mag, t;
    logic [127:0] prod;
    logic         neg;
    a    = 64'(pos) * 16;
    neg  = a < 64'(ctr);
    mag  = neg ? 64'(ctr) - a : a - 64'(ctr);
    t    = mag * 64'(d);
    prod = 128'(t) * 128'(inv) + (128'd1 << 23);
    if (prod[127:64] != 0) mag = 64'd1 << 40;
    else mag = prod[63:0] >> 24;
    if (!neg) return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    return 32'(64'h1_0000_0000 - mag);
  endfunction

  // Eroded mask: the whole clamped window must be set
  function automatic bit window_set(int row, int col);
    int rr, cc;
    for (int i = -HW; i <= HW; i++) begin
      rr = row + i;
      if (rr < 0) rr = 0;
      if (rr > int'(fr_h) - 1) rr = fr_h - 1;
      for (int j = -HW; j <= HW; j++) begin
        cc = col + j;
        if (cc < 0) cc = 0;
        if (cc > int'(fr_w) - 1) cc = fr_w - 1;
        if (!mask_mem[rr * fr_w + cc]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic point_item_t next_point();
    point_item_t p;
    logic [15:0] d;
    logic [31:0] c;
    bit          kept;
    d    = depth_mem[out_cnt];
    c    = colour_mem[out_cnt];
    kept = d >= reg_val[CFG_MIN_DEPTH][15:0] && d <= reg_val[CFG_MAX_DEPTH][15:0] &&
           window_set(out_row, out_col);
    p = '0;
    if (kept) begin
      p.keep      = 1'b1;
      p.x_pos     = back_project(out_col, reg_val[CFG_CENTER_X][13:0], d, reg_val[CFG_INV_FX]);
      p.y_pos     = back_project(out_row, reg_val[CFG_CENTER_Y][13:0], d, reg_val[CFG_INV_FY]);
      p.z_mm      = d;
      p.out_blue  = c[7:0];
      p.out_green = c[15:8];
      p.out_red   = c[23:16];
      p.out_alpha = c[31:24];
    end
    p.frame_last = (out_cnt + 1 == fr_pix);
    out_cnt++;
    out_col++;
    if (out_col >= fr_w) begin
      out_col = 0; out_row++;
    end
    if (out_cnt >= fr_pix) frame_idle();
    return p;
  endfunction

  function automatic bit tail_pending();
    return in_cnt != 0 && in_cnt == fr_pix && out_cnt < fr_pix;
  endfunction

  // Advance the predictor by one accepted item
  function automatic bit predict_item(pix_item_t it, output point_item_t p);
    p = '0;
    if (it.mode == MODE_FLUSH) begin
      if (!tail_pending()) return 1'b0;
      p = next_point();
      return 1'b1;
    end
    if (in_cnt != 0 && in_cnt == fr_pix) frame_idle();
    if (in_cnt == 0) begin
      fr_w   = clamp_size(reg_val[CFG_FRAME_W]);
      fr_h   = clamp_size(reg_val[CFG_FRAME_H]);
      fr_pix = fr_w * fr_h;
    end
    depth_mem[in_cnt]  = it.depth_mm;
    colour_mem[in_cnt] = {it.alpha, it.red, it.green, it.blue};
    mask_mem[in_cnt]   = it.mask_bit;
    in_cnt++;
    if (in_cnt > HW * fr_w + HW) begin
      p = next_point();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one item, wait for the handshake, then maybe open a gap
  task automatic send_item(pix_item_t it, bit has_fixed, point_item_t fixed);
    point_item_t p;
    int          gap;
    pix_ch.valid   <= 1'b1;
    pix_ch.payload <= it;
    offering = 1'b1;
    do @(posedge clk); while (!pix_ch.ready);
    if (predict_item(it, p)) point_q = {point_q, (has_fixed ? fixed : p)};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      gap = $urandom_range(1, 15);
      pix_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering, then wait for all expected points and a quiet spell
  task automatic wait_idle();
    if (offering) begin
      pix_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (point_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic write_regs(logic [23:0] vals [0:7]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      reg_val[i] = vals[i] & ((24'd1 << reg_width(i)) - 1);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pix_item_t make_pixel(logic [15:0] d, bit m);
    pix_item_t it;
    it          = '0;
    it.mode     = MODE_PIXEL;
    it.depth_mm = d;
    it.mask_bit = m;
    it.blue     = $urandom_range(0, 255);
    it.green    = $urandom_range(0, 255);
    it.red      = $urandom_range(0, 255);
    it.alpha    = $urandom_range(0, 255);
    return it;
  endfunction

  function automatic pix_item_t make_flush();
    pix_item_t it;
    it      = make_pixel($urandom_range(0, 65535), $urandom_range(0, 1));
    it.mode = MODE_FLUSH;
    return it;
  endfunction

  // Result side: stalls on its own pattern, one long hold-off on request
  int  hold_left;
  bit  hold_done;
  int  run_left;
  bit  run_busy;
  point_item_t got, want;

  always @(posedge clk) begin
    if (rst_n && pt_ch.valid && pt_ch.ready) begin
      got = pt_ch.payload;
      if (point_q.size() == 0) begin
        $error("point with no expectation: %p", got);
        err_cnt++;
      end else begin
        want = point_q.pop_front();
        if (got.keep !== want.keep) begin
          $error("keep: exp %0d act %0d", want.keep, got.keep); err_cnt++;
        end
        if (got.x_pos !== want.x_pos) begin
          $error("x_pos: exp %0d act %0d", want.x_pos, got.x_pos); err_cnt++;
        end
        if (got.y_pos !== want.y_pos) begin
          $error("y_pos: exp %0d act %0d", want.y_pos, got.y_pos); err_cnt++;
        end
        if (got.z_mm !== want.z_mm) begin
          $error("z_mm: exp %0d act %0d", want.z_mm, got.z_mm); err_cnt++;
        end
        if (got.out_blue !== want.out_blue) begin
          $error("out_blue: exp %0d act %0d", want.out_blue, got.out_blue); err_cnt++;
        end
        if (got.out_green !== want.out_green) begin
          $error("out_green: exp %0d act %0d", want.out_green, got.out_green); err_cnt++;
        end
        if (got.out_red !== want.out_red) begin
          $error("out_red: exp %0d act %0d", want.out_red, got.out_red); err_cnt++;
        end
        if (got.out_alpha !== want.out_alpha) begin
          $error("out_alpha: exp %0d act %0d", want.out_alpha, got.out_alpha); err_cnt++;
        end
        if (got.frame_last !== want.frame_last) begin
          $error("frame_last: exp %0d act %0d", want.frame_last, got.frame_last); err_cnt++;
        end
      end
    end
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      pt_ch.ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_busy = $urandom_range(0, 2) == 0;
        run_left = $urandom_range(1, 60);
      end
      run_left--;
      pt_ch.ready <= run_busy ? ($urandom_range(0, 1) == 1) : 1'b1;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  // Directed table
  typedef struct {
    pix_item_t   it;
    bit          fixed;
    point_item_t exp;
  } stim_row_t;

  stim_row_t table_rows[$];

  function automatic void add_row(pix_item_t it, bit fixed, point_item_t exp);
    stim_row_t r;
    r.it = it; r.fixed = fixed; r.exp = exp;
    table_rows = {table_rows, r};
  endfunction

  task automatic run_frame(bit drop_tail);
    int unsigned w, h, n, kind, hole;
    logic [15:0] d;
    bit          m;
    w    = clamp_size(reg_val[CFG_FRAME_W]);
    h    = clamp_size(reg_val[CFG_FRAME_H]);
    n    = w * h;
    kind = $urandom_range(0, 9);
    hole = $urandom_range(0, n - 1);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 1) == 0)
        d = $urandom_range(reg_val[CFG_MIN_DEPTH][15:0], 16'hFFFF);
      else
        d = $urandom_range(0, 65535);
      if (d > reg_val[CFG_MAX_DEPTH][15:0] && $urandom_range(0, 1) == 0)
        d = reg_val[CFG_MAX_DEPTH][15:0];
      m = kind < 6 ? 1'b1 : (kind < 9 ? (k != hole) : ($urandom_range(0, 7) != 0));
      send_item(make_pixel(d, m), 1'b0, '0);
      rand_sent++;
      if (rand_sent == 60) hold_req = 1'b1;
      if ($urandom_range(0, 40) == 0) send_item(make_flush(), 1'b0, '0);
    end
    if (drop_tail) return;
    while (tail_pending()) begin
      send_item(make_flush(), 1'b0, '0);
      rand_sent++;
    end
    repeat ($urandom_range(0, 2)) send_item(make_flush(), 1'b0, '0);
  endtask

  logic [23:0] regs_next [0:7];
  point_item_t none_pt, rej_pt;
  pix_item_t   px;
  int          frame_no;

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    pix_ch.valid   = 1'b0;
    pix_ch.payload = '0;
    pt_ch.ready    = 1'b0;
    err_cnt = 0; cyc_cnt = 0; burst_left = 0; rand_sent = 0; hold_req = 0;
    hold_left = 0; hold_done = 0; run_left = 0; run_busy = 0; offering = 0;
    reg_val[0] = RST_MIN_DEPTH; reg_val[1] = RST_MAX_DEPTH;
    reg_val[2] = RST_CENTER_X;  reg_val[3] = RST_CENTER_Y;
    reg_val[4] = RST_INV_FX;    reg_val[5] = RST_INV_FY;
    reg_val[6] = RST_FRAME_W;   reg_val[7] = RST_FRAME_H;
    fr_w = 1; fr_h = 1; fr_pix = 0;
    frame_idle();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Flush straight after reset is ignored
    none_pt = '0;
    send_item(make_flush(), 1'b0, none_pt);
    wait_idle();

    // 3x2 frame at default depth bounds and intrinsics
    regs_next = reg_val;
    regs_next[CFG_FRAME_W] = 3;
    regs_next[CFG_FRAME_H] = 2;
    write_regs(regs_next);

    // Frame one: a cleared mask bit rejects every pixel of a small frame
    add_row(make_pixel(16'd0, 1'b1), 1'b0, none_pt);
    add_row(make_pixel(16'hFFFF, 1'b1), 1'b0, none_pt);
    add_row(make_flush(), 1'b0, none_pt);           // mid-frame flush, ignored
    px = make_pixel(16'd10, 1'b0);
    px.blue = 8'hFF; px.green = 8'hFF; px.red = 8'hFF; px.alpha = 8'hFF;
    add_row(px, 1'b0, none_pt);
    px = make_pixel(16'd2000, 1'b1);
    px.blue = 8'h00; px.green = 8'h00; px.red = 8'h00; px.alpha = 8'h00;
    add_row(px, 1'b0, none_pt);
    add_row(make_pixel(16'd1, 1'b1), 1'b0, none_pt);
    add_row(make_pixel(16'd500, 1'b1), 1'b0, none_pt);
    for (int k = 0; k < 6; k++) begin
      rej_pt = '0;
      rej_pt.frame_last = (k == 5);
      add_row(make_flush(), 1'b1, rej_pt);
    end
    add_row(make_flush(), 1'b0, none_pt);            // tail drained, ignored
    // Frame two: full mask, depths at and just past the bounds
    add_row(make_pixel(16'd10, 1'b1), 1'b0, none_pt);
    add_row(make_pixel(16'd2000, 1'b1), 1'b0, none_pt);
    add_row(make_pixel(16'd9, 1'b1), 1'b0, none_pt);
    add_row(make_pixel(16'd2001, 1'b1), 1'b0, none_pt);
    add_row(make_pixel(16'd0, 1'b1), 1'b0, none_pt);
    add_row(make_pixel(16'd1000, 1'b1), 1'b0, none_pt);
    for (int k = 0; k < 6; k++) add_row(make_flush(), 1'b0, none_pt);

    foreach (table_rows[r]) send_item(table_rows[r].it, table_rows[r].fixed, table_rows[r].exp);
    wait_idle();

    // Random frames, new settings between them
    frame_no = 0;
    while (rand_sent < RAND_ITEMS || frame_no < 6) begin
      regs_next[CFG_MIN_DEPTH] = $urandom_range(0, 1500);
      regs_next[CFG_MAX_DEPTH] = $urandom_range(1000, 65535);
      regs_next[CFG_CENTER_X]  = $urandom_range(0, 16383);
      regs_next[CFG_CENTER_Y]  = $urandom_range(0, 16383);
      regs_next[CFG_INV_FX]    = $urandom_range(0, 200000);
      regs_next[CFG_INV_FY]    = $urandom_range(0, 200000);
      regs_next[CFG_FRAME_W]   = $urandom_range(1, 24);
      regs_next[CFG_FRAME_H]   = $urandom_range(1, 4);
      case (frame_no % 8)
        1: begin
          regs_next[CFG_MIN_DEPTH] = 0;     regs_next[CFG_MAX_DEPTH] = 16'hFFFF;
          regs_next[CFG_CENTER_X]  = 0;     regs_next[CFG_CENTER_Y]  = 14'h3FFF;
          regs_next[CFG_INV_FX]    = 24'hFFFFFF; regs_next[CFG_INV_FY] = 24'hFFFFFF;
        end
        2: begin
          regs_next[CFG_CENTER_X] = 14'h3FFF; regs_next[CFG_CENTER_Y] = 0;
          regs_next[CFG_INV_FX]   = 0;
          regs_next[CFG_FRAME_W]  = 0;        regs_next[CFG_FRAME_H]  = 0;
        end
        3: begin
          regs_next[CFG_MIN_DEPTH] = 16'hFFFF; regs_next[CFG_MAX_DEPTH] = 16'hFFFF;
          regs_next[CFG_FRAME_W]   = 0;
          regs_next[CFG_FRAME_H]   = $urandom_range(22, 30);
        end
        5: begin
          regs_next[CFG_FRAME_W] = $urandom_range(22, 24);
          regs_next[CFG_FRAME_H] = $urandom_range(3, 5);
          regs_next[CFG_INV_FX]  = $urandom_range(0, 24'hFFFFFF);
          regs_next[CFG_INV_FY]  = $urandom_range(0, 24'hFFFFFF);
        end
        default: ;
      endcase
      write_regs(regs_next);
      // Some frames lose their tail to the next frame's first pixel
      if ($urandom_range(0, 5) == 0) run_frame(1'b1);
      run_frame(1'b0);
      wait_idle();
      frame_no++;
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
